// File: rtl/ffsa_pkg.sv
// ----------------------------------------------------------------------------
// ffsa_pkg
// Shared constants and codes of the first-fit segment allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffsa_pkg;

  localparam int unsigned SegRecords = 64;

  localparam logic [31:0] HeapBaseReset  = 32'h0080_0000;
  localparam logic [31:0] HeapEndReset   = 32'h0120_0000;
  localparam logic [31:0] HeapBytesReset = HeapEndReset - HeapBaseReset;

  typedef enum logic [0:0] {
    CMD_ALLOC   = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NO_FIT  = 3'd1,
    ST_POOL    = 3'd2,
    ST_UNKNOWN = 3'd3,
    ST_ZERO    = 3'd4
  } status_e;

  typedef enum logic [0:0] {
    REG_HEAP_BASE  = 1'b0,
    REG_HEAP_BYTES = 1'b1
  } reg_idx_e;

endpackage

`default_nettype wire

// File: rtl/ffsa_mem.sv
// ----------------------------------------------------------------------------
// ffsa_mem
// Segment record store: start, length and link, one write port with a
// per-field enable and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ffsa_mem #(
  parameter int unsigned N = ffsa_pkg::SegRecords
) (
  input  wire logic                   clk_i,
  input  wire logic                   we_start_i,
  input  wire logic                   we_len_i,
  input  wire logic                   we_link_i,
  input  wire logic [$clog2(N)-1:0]   waddr_i,
  input  wire logic [31:0]            wstart_i,
  input  wire logic [31:0]            wlen_i,
  input  wire logic [$clog2(N+1)-1:0] wlink_i,
  input  wire logic [$clog2(N)-1:0]   raddr_i,
  output logic      [31:0]            rstart_o,
  output logic      [31:0]            rlen_o,
  output logic      [$clog2(N+1)-1:0] rlink_o
);

  logic [31:0]            start_mem [N];
  logic [31:0]            len_mem   [N];
  logic [$clog2(N+1)-1:0] link_mem  [N];

  always_ff @(posedge clk_i) begin
    if (we_start_i) start_mem[waddr_i] <= wstart_i;
    if (we_len_i)   len_mem[waddr_i]   <= wlen_i;
    if (we_link_i)  link_mem[waddr_i]  <= wlink_i;
    rstart_o <= start_mem[raddr_i];
    rlen_o   <= len_mem[raddr_i];
    rlink_o  <= link_mem[raddr_i];
  end

endmodule

`default_nettype wire

// File: rtl/first_fit_segment_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_segment_allocator
// First-fit heap segment manager over a pool of segment records.
// ----------------------------------------------------------------------------
// Requests come in as beats on the s_axis channel: tuser carries the command
// (allocate or release), tdata the request size and the release address.
// Each request gives one result beat on m_axis with status, granted address
// and the free byte total after the request.
// A request is worked by one sequencer over a single record memory port:
// walking a list reads and then checks each visited record in turn, and an
// allocate that fits then scans the pool for an unused record the same way,
// plus up to three write steps and a step to hand over the result.
// The input side is ready only while the sequencer is idle. A finished result
// sits in an output register, so a new request is taken while the receiver
// stalls; the sequencer then waits with its next result until that register
// is free.
// After reset, and after every configuration write, a clearing pass over all
// SEG_RECORDS records rebuilds the pool from heap_base and heap_bytes; no
// request is taken during it.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_segment_allocator #(
  parameter int unsigned SEG_RECORDS = ffsa_pkg::SegRecords
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [63:0] s_axis_tdata_i,   // request_bytes[31:0], release_addr[63:32]
  input  wire logic [0:0]  s_axis_tuser_i,   // cmd[0]
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic      [71:0] m_axis_tdata_o    // status[2:0], granted_addr[34:3],
                                             // free_bytes[66:35], zero[71:67]
);

  localparam int unsigned AW = $clog2(SEG_RECORDS);
  localparam int unsigned IW = $clog2(SEG_RECORDS + 1);
  localparam logic [IW-1:0] NullIdx = IW'(SEG_RECORDS);
  localparam logic [AW-1:0] LastIdx = AW'(SEG_RECORDS - 1);

  typedef enum logic [9:0] {
    S_CLEAR = 10'b00_0000_0001,
    S_IDLE  = 10'b00_0000_0010,
    S_WRD   = 10'b00_0000_0100,
    S_WCHK  = 10'b00_0000_1000,
    S_SRD   = 10'b00_0001_0000,
    S_SCHK  = 10'b00_0010_0000,
    S_WR1   = 10'b00_0100_0000,
    S_WR2   = 10'b00_1000_0000,
    S_WR3   = 10'b01_0000_0000,
    S_DONE  = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  logic [31:0]   heap_base_q, heap_base_d, heap_bytes_q, heap_bytes_d;
  logic [IW-1:0] free_head_q, free_head_d, used_head_q, used_head_d;
  logic [31:0]   free_total_q, free_total_d, used_total_q, used_total_d;
  logic [AW-1:0] clr_idx_q, clr_idx_d, scan_q, scan_d, nr_q, nr_d;
  logic [IW-1:0] cur_q, cur_d, prev_q, prev_d, cur_link_q, cur_link_d;
  logic [31:0]   cur_start_q, cur_start_d, cur_len_q, cur_len_d;
  logic          cmd_q, cmd_d;
  logic [31:0]   req_q, req_d, addr_q, addr_d;
  logic [2:0]    status_q, status_d;
  logic [31:0]   granted_q, granted_d;
  logic          out_valid_q, out_valid_d;
  logic [66:0]   out_data_q, out_data_d;

  logic          we_start, we_len, we_link;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wstart, wlen;
  logic [IW-1:0] wlink;
  logic [31:0]   rstart, rlen;
  logic [IW-1:0] rlink;
  logic [31:0]   remain;

  ffsa_mem #(.N(SEG_RECORDS)) u_mem (
    .clk_i      (clk_i),
    .we_start_i (we_start),
    .we_len_i   (we_len),
    .we_link_i  (we_link),
    .waddr_i    (waddr),
    .wstart_i   (wstart),
    .wlen_i     (wlen),
    .wlink_i    (wlink),
    .raddr_i    (raddr),
    .rstart_o   (rstart),
    .rlen_o     (rlen),
    .rlink_o    (rlink)
  );

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'd0, out_data_q};
  assign remain          = cur_len_q - req_q;

  always_comb begin
    state_d      = state_q;
    heap_base_d  = heap_base_q;
    heap_bytes_d = heap_bytes_q;
    free_head_d  = free_head_q;
    used_head_d  = used_head_q;
    free_total_d = free_total_q;
    used_total_d = used_total_q;
    clr_idx_d    = clr_idx_q;
    scan_d       = scan_q;
    nr_d         = nr_q;
    cur_d        = cur_q;
    prev_d       = prev_q;
    cur_link_d   = cur_link_q;
    cur_start_d  = cur_start_q;
    cur_len_d    = cur_len_q;
    cmd_d        = cmd_q;
    req_d        = req_q;
    addr_d       = addr_q;
    status_d     = status_q;
    granted_d    = granted_q;
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    we_start     = 1'b0;
    we_len       = 1'b0;
    we_link      = 1'b0;
    waddr        = clr_idx_q;
    wstart       = '0;
    wlen         = '0;
    wlink        = NullIdx;
    raddr        = cur_q[AW-1:0];

    if (out_valid_q && m_axis_tready_i) out_valid_d = 1'b0;

    case (state_q)
      S_CLEAR: begin
        we_start = 1'b1;
        we_len   = 1'b1;
        we_link  = 1'b1;
        if (clr_idx_q == '0 && heap_bytes_q != '0) begin
          wstart = heap_base_q;
          wlen   = heap_bytes_q;
        end
        if (clr_idx_q == LastIdx) state_d = S_IDLE;
        else clr_idx_d = clr_idx_q + 1'b1;
      end
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          cmd_d     = s_axis_tuser_i[0];
          req_d     = s_axis_tdata_i[31:0];
          addr_d    = s_axis_tdata_i[63:32];
          prev_d    = NullIdx;
          status_d  = ffsa_pkg::ST_OK;
          granted_d = '0;
          if (s_axis_tuser_i[0] == ffsa_pkg::CMD_RELEASE) begin
            cur_d   = used_head_q;
            state_d = S_WRD;
          end else if (s_axis_tdata_i[31:0] == '0) begin
            status_d = ffsa_pkg::ST_ZERO;
            state_d  = S_DONE;
          end else begin
            cur_d   = free_head_q;
            state_d = S_WRD;
          end
        end
      end
      S_WRD: begin
        if (cur_q == NullIdx) begin
          status_d = (cmd_q == ffsa_pkg::CMD_RELEASE) ? ffsa_pkg::ST_UNKNOWN
                                                      : ffsa_pkg::ST_NO_FIT;
          state_d  = S_DONE;
        end else begin
          state_d = S_WCHK;
        end
      end
      S_WCHK: begin
        cur_start_d = rstart;
        cur_len_d   = rlen;
        cur_link_d  = rlink;
        if (cmd_q == ffsa_pkg::CMD_RELEASE ? (rstart == addr_q) : (rlen >= req_q)) begin
          scan_d  = '0;
          state_d = (cmd_q == ffsa_pkg::CMD_RELEASE) ? S_WR1 : S_SRD;
        end else begin
          prev_d  = cur_q;
          cur_d   = rlink;
          state_d = S_WRD;
        end
      end
      S_SRD: begin
        raddr   = scan_q;
        state_d = S_SCHK;
      end
      S_SCHK: begin
        if (rlen == '0) begin
          nr_d    = scan_q;
          state_d = S_WR1;
        end else if (scan_q == LastIdx) begin
          status_d = ffsa_pkg::ST_POOL;
          state_d  = S_DONE;
        end else begin
          scan_d  = scan_q + 1'b1;
          state_d = S_SRD;
        end
      end
      S_WR1: begin
        if (cmd_q == ffsa_pkg::CMD_RELEASE) begin
          // Unlinked record goes to the head of the free list.
          we_link      = 1'b1;
          waddr        = cur_q[AW-1:0];
          wlink        = free_head_q;
          free_head_d  = cur_q;
          free_total_d = free_total_q + cur_len_q;
          used_total_d = used_total_q - cur_len_q;
          if (prev_q == NullIdx) begin
            used_head_d = cur_link_q;
            state_d     = S_DONE;
          end else begin
            state_d = S_WR3;
          end
        end else begin
          we_start     = 1'b1;
          we_len       = 1'b1;
          we_link      = 1'b1;
          waddr        = nr_q;
          wstart       = cur_start_q;
          wlen         = req_q;
          wlink        = used_head_q;
          used_head_d  = IW'(nr_q);
          used_total_d = used_total_q + req_q;
          free_total_d = free_total_q - req_q;
          granted_d    = cur_start_q;
          state_d      = S_WR2;
        end
      end
      S_WR2: begin
        we_start = 1'b1;
        we_len   = 1'b1;
        waddr    = cur_q[AW-1:0];
        if (remain == '0) begin
          // Exact fit: the emptied record leaves the free list.
          we_link = 1'b1;
          if (prev_q == NullIdx) begin
            free_head_d = cur_link_q;
            state_d     = S_DONE;
          end else begin
            state_d = S_WR3;
          end
        end else begin
          wstart  = cur_start_q + req_q;
          wlen    = remain;
          state_d = S_DONE;
        end
      end
      S_WR3: begin
        we_link = 1'b1;
        waddr   = prev_q[AW-1:0];
        wlink   = cur_link_q;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = {free_total_q, granted_q, status_q};
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase

    // A register write reinitializes the pool from the new region.
    if (cfg_we_i) begin
      if (cfg_idx_i == ffsa_pkg::REG_HEAP_BASE) heap_base_d = cfg_wdata_i;
      else heap_bytes_d = cfg_wdata_i;
      free_total_d = (cfg_idx_i == ffsa_pkg::REG_HEAP_BYTES) ? cfg_wdata_i : heap_bytes_q;
      free_head_d  = (free_total_d != '0) ? '0 : NullIdx;
      used_head_d  = NullIdx;
      used_total_d = '0;
      clr_idx_d    = '0;
      state_d      = S_CLEAR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      heap_base_q  <= ffsa_pkg::HeapBaseReset;
      heap_bytes_q <= ffsa_pkg::HeapBytesReset;
      free_head_q  <= '0;
      used_head_q  <= NullIdx;
      free_total_q <= ffsa_pkg::HeapBytesReset;
      used_total_q <= '0;
      clr_idx_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      heap_base_q  <= heap_base_d;
      heap_bytes_q <= heap_bytes_d;
      free_head_q  <= free_head_d;
      used_head_q  <= used_head_d;
      free_total_q <= free_total_d;
      used_total_q <= used_total_d;
      clr_idx_q    <= clr_idx_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q      <= scan_d;
    nr_q        <= nr_d;
    cur_q       <= cur_d;
    prev_q      <= prev_d;
    cur_link_q  <= cur_link_d;
    cur_start_q <= cur_start_d;
    cur_len_q   <= cur_len_d;
    cmd_q       <= cmd_d;
    req_q       <= req_d;
    addr_q      <= addr_d;
    status_q    <= status_d;
    granted_q   <= granted_d;
    out_data_q  <= out_data_d;
  end

  // The new record of an allocate is never the segment being split.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WR1 && cmd_q == ffsa_pkg::CMD_ALLOC) |-> (IW'(nr_q) != cur_q))
    else $error("allocated record aliases the split segment");

  // List heads always hold a record index or the null marker.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (free_head_q <= NullIdx) && (used_head_q <= NullIdx))
    else $error("list head out of range");

  // A result is handed over only into a free or draining output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !cfg_we_i && (!out_valid_q || m_axis_tready_i))
      |=> (out_valid_q && state_q == S_IDLE))
    else $error("result not delivered to output register");

  // A held result is not overwritten while the receiver stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |=> $stable(out_data_q))
    else $error("stalled result changed");

endmodule

`default_nettype wire
